// ----- hdl/bsrt_pkg.sv -----
// Shared types and constants for the bit-stream randomness test unit.
`default_nettype none

package bsrt_pkg;

  // Widths of the result fields as they leave the block.
  localparam int ONES_W   = 18;
  localparam int RUNS_W   = 18;
  localparam int WORDS_W  = 13;
  localparam int S2_OUT_W = 33;
  localparam int S4_OUT_W = 31;

  // Input word and register port geometry.
  localparam int WORD_W  = 32;
  localparam int THR_W   = 16;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_Z_LIMIT  = 3'd0;
  localparam logic [2:0] REG_PAIR_LO  = 3'd1;
  localparam logic [2:0] REG_PAIR_HI  = 3'd2;
  localparam logic [2:0] REG_NIB_LO   = 3'd3;
  localparam logic [2:0] REG_NIB_HI   = 3'd4;

  // Register reset values (Q8.8).
  localparam logic [THR_W-1:0] Z_LIMIT_RST = 16'd983;
  localparam logic [THR_W-1:0] PAIR_LO_RST = 16'd46;
  localparam logic [THR_W-1:0] PAIR_HI_RST = 16'd2387;
  localparam logic [THR_W-1:0] NIB_LO_RST  = 16'd1598;
  localparam logic [THR_W-1:0] NIB_HI_RST  = 16'd7037;

  // Sequencer step counter: pair position during a word, multiplier
  // operation during the end-of-sample phase.
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] PAIR_STEP_LAST = 5'd15;

  localparam logic [STEP_W-1:0] OP_NIB_FIRST  = 5'd4;
  localparam logic [STEP_W-1:0] OP_FREQ_SQ    = 5'd20;
  localparam logic [STEP_W-1:0] OP_FREQ_LIM   = 5'd21;
  localparam logic [STEP_W-1:0] OP_RUNS_SQ    = 5'd22;
  localparam logic [STEP_W-1:0] OP_RUNS_LIM   = 5'd23;
  localparam logic [STEP_W-1:0] OP_PAIR_SQ    = 5'd24;
  localparam logic [STEP_W-1:0] OP_PAIR_LO    = 5'd25;
  localparam logic [STEP_W-1:0] OP_PAIR_HI    = 5'd26;
  localparam logic [STEP_W-1:0] OP_NIB_SQ     = 5'd27;
  localparam logic [STEP_W-1:0] OP_NIB_LO     = 5'd28;
  localparam logic [STEP_W-1:0] OP_NIB_HI     = 5'd29;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORD,
    ST_SUM,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/bit_stream_randomness_tests_unit.sv -----
// Bit-stream randomness test unit: monobit, runs, pair and nibble tests over a word stream.
// A counted word is accepted in IDLE and then walked one 2-bit pair per cycle through the
// bin update path; a word beyond MAX_WORDS is accepted uncounted and marks the overflow.
// The word marked last then runs the square sums and tests on the one shared
// multiplier (30 operations plus one drain), after which the result register is loaded
// and its result transfer is offered.
// Reset is synchronous: thresholds return to their defaults and the sample is cleared.
`default_nettype none

module bit_stream_randomness_tests_unit #(
  parameter int MAX_WORDS = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input word channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [bsrt_pkg::WORD_W-1:0]    word_in,
  input  wire logic                           last_word,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [bsrt_pkg::ONES_W-1:0]         ones_total,
  output logic [bsrt_pkg::RUNS_W-1:0]         runs_total,
  output logic [bsrt_pkg::WORDS_W-1:0]        words_seen,
  output logic [bsrt_pkg::S2_OUT_W-1:0]       pair_square_sum,
  output logic [bsrt_pkg::S4_OUT_W-1:0]       nibble_square_sum,
  output logic                                frequency_pass,
  output logic                                runs_pass,
  output logic                                pair_pass,
  output logic                                nibble_pass,
  output logic                                overflow_flag,
  // configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bsrt_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [bsrt_pkg::DATA_W-1:0]    pwdata,
  output logic [bsrt_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  import bsrt_pkg::*;

  // Word count must hold MAX_WORDS itself. One and run counts reach 32 per
  // word, pair bins 16 and nibble bins 8 per word.
  localparam int WW  = $clog2(MAX_WORDS + 1);
  localparam int CW  = WW + 5;
  localparam int PBW = WW + 4;
  localparam int NBW = WW + 3;
  localparam int S2W = 2 * PBW;
  localparam int S4W = 2 * NBW;
  // Multiplier operands: the widest is the runs deviation, below 64 per word,
  // or a 16-bit threshold.
  localparam int MW  = (WW + 6 > THR_W) ? WW + 6 : THR_W;
  localparam int PW  = 2 * MW;

  // ---------------------------------------------------------------------
  // Configuration registers. pready is always high, so a write lands on the
  // access cycle. Writes to unused addresses are dropped.
  // ---------------------------------------------------------------------
  logic [THR_W-1:0] z_limit_squared;
  logic [THR_W-1:0] pair_chi_low;
  logic [THR_W-1:0] pair_chi_high;
  logic [THR_W-1:0] nibble_chi_low;
  logic [THR_W-1:0] nibble_chi_high;
  logic [2:0]       reg_idx;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      z_limit_squared <= Z_LIMIT_RST;
      pair_chi_low    <= PAIR_LO_RST;
      pair_chi_high   <= PAIR_HI_RST;
      nibble_chi_low  <= NIB_LO_RST;
      nibble_chi_high <= NIB_HI_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_Z_LIMIT: z_limit_squared <= pwdata[THR_W-1:0];
        REG_PAIR_LO: pair_chi_low    <= pwdata[THR_W-1:0];
        REG_PAIR_HI: pair_chi_high   <= pwdata[THR_W-1:0];
        REG_NIB_LO:  nibble_chi_low  <= pwdata[THR_W-1:0];
        REG_NIB_HI:  nibble_chi_high <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_Z_LIMIT: prdata = DATA_W'(z_limit_squared);
      REG_PAIR_LO: prdata = DATA_W'(pair_chi_low);
      REG_PAIR_HI: prdata = DATA_W'(pair_chi_high);
      REG_NIB_LO:  prdata = DATA_W'(nibble_chi_low);
      REG_NIB_HI:  prdata = DATA_W'(nibble_chi_high);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer. IDLE takes a word. WORD walks the 16 aligned pairs of it,
  // one per cycle. SUM drives the shared multiplier through the square
  // sums and the four tests. DONE waits for the result register to free.
  // ---------------------------------------------------------------------
  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic              in_take;
  logic              word_fits;
  logic              word_active;
  logic              pair_done;
  logic              issue;
  logic              load;
  logic              last_q;
  logic              prod_valid;
  logic [STEP_W-1:0] prod_step;

  logic [WW-1:0]     word_acc;

  assign in_take   = in_valid & ~in_stall;
  assign word_fits = (word_acc < WW'(MAX_WORDS));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (word_fits) begin
            state_next = ST_WORD;
          end else if (last_word) begin
            state_next = ST_SUM;
          end
        end
      end
      ST_WORD: begin
        if (step == PAIR_STEP_LAST) begin
          state_next = last_q ? ST_SUM : ST_IDLE;
        end
      end
      ST_SUM: begin
        if (prod_valid && (prod_step == OP_NIB_HI)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    word_active = 1'b0;
    issue       = 1'b0;
    load        = 1'b0;
    case (state)
      ST_IDLE: in_stall    = 1'b0;
      ST_WORD: word_active = 1'b1;
      ST_SUM:  issue       = (step <= OP_NIB_HI);
      ST_DONE: load        = ~out_valid | ~out_stall;
      default: in_stall    = 1'b1;
    endcase
  end

  assign pair_done = word_active & (step == PAIR_STEP_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      prod_valid <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      state      <= state_next;
      prod_valid <= issue;
      if (state != state_next) begin
        step <= '0;
      end else if (word_active || issue) begin
        step <= step + STEP_W'(1);
      end
      if (in_take) begin
        last_q <= last_word;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Per-word accumulation. The word is shifted left two bits a cycle; the
  // top pair feeds the pair bins, ones and runs, and on even steps the top
  // nibble feeds the nibble bins. Runs restart on the first word of a sample.
  // ---------------------------------------------------------------------
  logic [WORD_W-1:0] word_sh;
  logic [CW-1:0]     ones_acc;
  logic [CW-1:0]     runs_acc;
  logic              previous_bit;
  logic              overflow_seen;
  logic [PBW-1:0]    pair_bins   [4];
  logic [NBW-1:0]    nibble_bins [16];
  logic [1:0]        pair_idx;
  logic [3:0]        nib_idx;
  logic [STEP_W-1:0] nib_step;
  logic              bit_hi;
  logic              bit_lo;
  logic              edge_hi;
  logic              edge_lo;

  assign bit_hi   = word_sh[WORD_W-1];
  assign bit_lo   = word_sh[WORD_W-2];
  assign edge_hi  = ((step == '0) && (word_acc == '0)) ? 1'b1 : (bit_hi != previous_bit);
  assign edge_lo  = (bit_hi != bit_lo);
  assign nib_step = step - OP_NIB_FIRST;
  assign pair_idx = word_active ? word_sh[WORD_W-1:WORD_W-2] : step[1:0];
  assign nib_idx  = word_active ? word_sh[WORD_W-1:WORD_W-4] : nib_step[3:0];

  always_ff @(posedge clk) begin
    if (in_take) begin
      word_sh <= word_in;
    end else if (word_active) begin
      word_sh <= {word_sh[WORD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || load) begin
      ones_acc      <= '0;
      runs_acc      <= '0;
      word_acc      <= '0;
      previous_bit  <= 1'b0;
      overflow_seen <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        pair_bins[i] <= '0;
      end
      for (int i = 0; i < 16; i++) begin
        nibble_bins[i] <= '0;
      end
    end else begin
      if (in_take && !word_fits) begin
        overflow_seen <= 1'b1;
      end
      if (word_active) begin
        ones_acc           <= ones_acc + CW'(bit_hi) + CW'(bit_lo);
        runs_acc           <= runs_acc + CW'(edge_hi) + CW'(edge_lo);
        previous_bit       <= bit_lo;
        pair_bins[pair_idx] <= pair_bins[pair_idx] + PBW'(1);
        if (!step[0]) begin
          nibble_bins[nib_idx] <= nibble_bins[nib_idx] + NBW'(1);
        end
      end
      if (pair_done) begin
        word_acc <= word_acc + WW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // End-of-sample arithmetic on one registered multiplier. Operations, by
  // step: squares of the four pair bins, squares of the sixteen nibble
  // bins, then for each z test the squared deviation and the limit times
  // the bit count or, for runs, twice the bit count less one, and for each chi-square
  // test the squared total followed by the low and high bound times that total. The
  // product is consumed in the cycle after issue; `held` keeps the left side of a test.
  // ---------------------------------------------------------------------
  logic [MW-1:0]   op_a;
  logic [MW-1:0]   op_b;
  logic [PW-1:0]   prod;
  logic [PW-1:0]   held;
  logic [S2W-1:0]  s2_acc;
  logic [S4W-1:0]  s4_acc;
  logic [MW-1:0]   dev_freq;
  logic [MW-1:0]   dev_runs;
  logic [MW-1:0]   n_bits;
  logic [MW-1:0]   m_runs;
  logic [MW-1:0]   p_pairs;
  logic [MW-1:0]   b_nibs;
  logic [MW-1:0]   ones2;
  logic [MW-1:0]   runs2;
  logic [PW+7:0]   scaled;
  logic [PW+7:0]   prod_ext;
  logic            held_le;
  logic            held_ge;
  logic            lo_ok;
  logic            freq_ok;
  logic            runs_ok;
  logic            pair_ok;
  logic            nib_ok;

  assign n_bits  = MW'({word_acc, 5'b00000});
  assign m_runs  = MW'({word_acc, 6'b000000}) - MW'(1);
  assign p_pairs = MW'({word_acc, 4'b0000});
  assign b_nibs  = MW'({word_acc, 3'b000});
  assign ones2   = MW'({ones_acc, 1'b0});
  assign runs2   = MW'({runs_acc, 1'b0});

  always_comb begin
    op_a = MW'(pair_bins[pair_idx]);
    op_b = MW'(pair_bins[pair_idx]);
    case (step)
      OP_FREQ_SQ: begin
        op_a = dev_freq;
        op_b = dev_freq;
      end
      OP_FREQ_LIM: begin
        op_a = MW'(z_limit_squared);
        op_b = n_bits;
      end
      OP_RUNS_SQ: begin
        op_a = dev_runs;
        op_b = dev_runs;
      end
      OP_RUNS_LIM: begin
        op_a = MW'(z_limit_squared);
        op_b = m_runs;
      end
      OP_PAIR_SQ: begin
        op_a = p_pairs;
        op_b = p_pairs;
      end
      OP_PAIR_LO: begin
        op_a = MW'(pair_chi_low);
        op_b = p_pairs;
      end
      OP_PAIR_HI: begin
        op_a = MW'(pair_chi_high);
        op_b = p_pairs;
      end
      OP_NIB_SQ: begin
        op_a = b_nibs;
        op_b = b_nibs;
      end
      OP_NIB_LO: begin
        op_a = MW'(nibble_chi_low);
        op_b = b_nibs;
      end
      OP_NIB_HI: begin
        op_a = MW'(nibble_chi_high);
        op_b = b_nibs;
      end
      default: begin
        if (step >= OP_NIB_FIRST) begin
          op_a = MW'(nibble_bins[nib_idx]);
          op_b = MW'(nibble_bins[nib_idx]);
        end
      end
    endcase
  end

  // Both tests compare 256 times the held value against the current product.
  assign scaled   = {held, 8'h00};
  assign prod_ext = {8'h00, prod};
  assign held_le  = (scaled <= prod_ext);
  assign held_ge  = (prod_ext <= scaled);

  always_ff @(posedge clk) begin
    if (issue) begin
      prod <= {{MW{1'b0}}, op_a} * {{MW{1'b0}}, op_b};
    end
    prod_step <= step;
    // The counts are final once the sequencer reaches SUM, so the absolute
    // deviations are captured on its first cycle.
    if (issue && (step == '0)) begin
      dev_freq <= (ones2 >= n_bits) ? ones2 - n_bits : n_bits - ones2;
      dev_runs <= (runs2 >= m_runs) ? runs2 - m_runs : m_runs - runs2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || load) begin
      s2_acc <= '0;
      s4_acc <= '0;
    end else if (prod_valid) begin
      if (prod_step < OP_NIB_FIRST) begin
        s2_acc <= s2_acc + prod[S2W-1:0];
      end else if (prod_step < OP_FREQ_SQ) begin
        s4_acc <= s4_acc + prod[S4W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid) begin
      case (prod_step)
        OP_FREQ_SQ:  held    <= prod;
        OP_FREQ_LIM: freq_ok <= held_le;
        OP_RUNS_SQ:  held    <= prod;
        OP_RUNS_LIM: runs_ok <= held_le;
        OP_PAIR_SQ:  held    <= (PW'(s2_acc) << 2) - prod;
        OP_PAIR_LO:  lo_ok   <= held_ge;
        OP_PAIR_HI:  pair_ok <= lo_ok & held_le;
        OP_NIB_SQ:   held    <= (PW'(s4_acc) << 4) - prod;
        OP_NIB_LO:   lo_ok   <= held_ge;
        OP_NIB_HI:   nib_ok  <= lo_ok & held_le;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Result register. It is loaded from DONE once empty or being taken in
  // this cycle, so the next sample can start while a result waits for its
  // transfer. An empty sample reports all tests as failed.
  // ---------------------------------------------------------------------
  logic out_valid_next;
  logic any_words;

  assign any_words = (word_acc != '0);

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ones_total        <= ONES_W'(ones_acc);
      runs_total        <= RUNS_W'(runs_acc);
      words_seen        <= WORDS_W'(word_acc);
      pair_square_sum   <= S2_OUT_W'(s2_acc);
      nibble_square_sum <= S4_OUT_W'(s4_acc);
      frequency_pass    <= any_words & freq_ok;
      runs_pass         <= any_words & runs_ok;
      pair_pass         <= any_words & pair_ok;
      nibble_pass       <= any_words & nib_ok;
      overflow_flag     <= overflow_seen;
    end
  end

endmodule

`default_nettype wire

// ----- dv/bit_stream_randomness_tests_unit_test.sv -----
// Self-checking testbench for the bit-stream randomness test unit.
`default_nettype none

module bit_stream_randomness_tests_unit_test;
  import bsrt_pkg::*;

  // The block is built with its default word bound. Samples here stay far
  // below it, which keeps the run to a modest number of words.
  localparam int MAX_WORDS        = 4096;
  // The drain wait before a register write or the end of the run leaves a margin
  // on the block's end-of-sample work after the last result.
  localparam int DRAIN_CYCLES     = 64;
  localparam int LONG_HOLD_CYCLES = 1500;
  localparam int LIMIT_CYCLES     = 1000000;
  localparam int REG_SLOTS        = 1 << (ADDR_W - 2);
  localparam int MAX_REPORTS      = 10;

  // One end-of-sample result, at the widths of the result ports.
  typedef struct {
    logic [ONES_W-1:0]   ones;
    logic [RUNS_W-1:0]   runs;
    logic [WORDS_W-1:0]  words;
    logic [S2_OUT_W-1:0] pair_sq;
    logic [S4_OUT_W-1:0] nib_sq;
    logic                freq_ok;
    logic                runs_ok;
    logic                pair_ok;
    logic                nib_ok;
    logic                ovf;
  } sample_result_t;

  // Keeps a copy of the thresholds and of the running sample statistics,
  // predicts the result of every sample and holds the predictions in order.
  class sample_scoreboard;
    logic [THR_W-1:0]   z_lim, pair_lo, pair_hi, nib_lo, nib_hi;
    logic [ONES_W-1:0]  ones_cnt;
    logic [RUNS_W-1:0]  runs_cnt;
    logic [WORDS_W-1:0] word_cnt;
    logic               prev_bit;
    logic               ovf;
    logic [16:0]        pair_bins [4];
    logic [15:0]        nib_bins [16];
    sample_result_t     expected [$];
    int                 errors;

    function new();
      z_lim   = Z_LIMIT_RST;
      pair_lo = PAIR_LO_RST;
      pair_hi = PAIR_HI_RST;
      nib_lo  = NIB_LO_RST;
      nib_hi  = NIB_HI_RST;
      errors  = 0;
      clear_sample();
    endfunction

    function void clear_sample();
      ones_cnt = '0;
      runs_cnt = '0;
      word_cnt = '0;
      prev_bit = 1'b0;
      ovf      = 1'b0;
      foreach (pair_bins[k]) pair_bins[k] = '0;
      foreach (nib_bins[k]) nib_bins[k] = '0;
    endfunction

    function void set_register(logic [2:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_Z_LIMIT: z_lim   = value[THR_W-1:0];
        REG_PAIR_LO: pair_lo = value[THR_W-1:0];
        REG_PAIR_HI: pair_hi = value[THR_W-1:0];
        REG_NIB_LO:  nib_lo  = value[THR_W-1:0];
        REG_NIB_HI:  nib_hi  = value[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [THR_W-1:0] register_value(logic [2:0] idx);
      case (idx)
        REG_Z_LIMIT: return z_lim;
        REG_PAIR_LO: return pair_lo;
        REG_PAIR_HI: return pair_hi;
        REG_NIB_LO:  return nib_lo;
        REG_NIB_HI:  return nib_hi;
        default:     return '0;
      endcase
    endfunction

    // |a - b| squared, in Q8.8, against the squared z limit times denom.
    function bit z_ok(longint unsigned a, longint unsigned b, longint unsigned denom);
      longint unsigned mag, lim;
      mag = (a >= b) ? a - b : b - a;
      lim = z_lim;
      return mag * mag * 256 <= lim * denom;
    endfunction

    function bit chi_ok(longint unsigned num, longint unsigned cnt,
                        logic [THR_W-1:0] lo, logic [THR_W-1:0] hi);
      longint unsigned scaled, lo_l, hi_l;
      scaled = num * 256;
      lo_l   = lo;
      hi_l   = hi;
      return lo_l * cnt <= scaled && scaled <= hi_l * cnt;
    endfunction

    function void note_word(logic [WORD_W-1:0] w, logic last);
      longint unsigned s2, s4, n, p, b, m, t;
      logic [5:0] inner;
      sample_result_t r;
      if (word_cnt < MAX_WORDS) begin
        // Runs inside the word are its bit changes; a change at the word
        // boundary opens one more run, except on the first word of a sample.
        inner = 6'($countones((w ^ (w >> 1)) & 32'h7FFF_FFFF));
        if (word_cnt == 0) begin
          runs_cnt = RUNS_W'(1) + RUNS_W'(inner);
        end else begin
          runs_cnt = runs_cnt + RUNS_W'(inner) +
                     ((w[WORD_W-1] != prev_bit) ? RUNS_W'(1) : RUNS_W'(0));
        end
        prev_bit = w[0];
        ones_cnt = ones_cnt + ONES_W'($countones(w));
        for (int k = 0; k < 16; k++) pair_bins[w[31 - 2*k -: 2]]++;
        for (int k = 0; k < 8; k++) nib_bins[w[31 - 4*k -: 4]]++;
        word_cnt++;
      end else begin
        ovf = 1'b1;
      end
      if (!last) return;

      s2 = 0;
      s4 = 0;
      foreach (pair_bins[k]) begin
        t = pair_bins[k];
        s2 += t * t;
      end
      foreach (nib_bins[k]) begin
        t = nib_bins[k];
        s4 += t * t;
      end
      r.ones    = ones_cnt;
      r.runs    = runs_cnt;
      r.words   = word_cnt;
      r.pair_sq = s2[S2_OUT_W-1:0];
      r.nib_sq  = s4[S4_OUT_W-1:0];
      r.ovf     = ovf;
      r.freq_ok = 1'b0;
      r.runs_ok = 1'b0;
      r.pair_ok = 1'b0;
      r.nib_ok  = 1'b0;
      if (word_cnt != 0) begin
        n = 32 * longint'(word_cnt);
        p = 16 * longint'(word_cnt);
        b = 8 * longint'(word_cnt);
        m = 2 * n - 1;
        t = ones_cnt;
        r.freq_ok = z_ok(2 * t, n, n);
        t = runs_cnt;
        r.runs_ok = z_ok(2 * t, m, m);
        r.pair_ok = chi_ok(4 * s2 - p * p, p, pair_lo, pair_hi);
        r.nib_ok  = chi_ok(16 * s4 - b * b, b, nib_lo, nib_hi);
      end
      expected.insert(expected.size(), r);
      clear_sample();
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch on %s: expected %0h, got %0h", name, exp_v, act_v);
      end
    endfunction

    function void check_result(sample_result_t got);
      sample_result_t want;
      if (expected.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("result transfer with none expected: ones %0h runs %0h words %0h",
                   got.ones, got.runs, got.words);
        return;
      end
      want = expected.pop_front();
      compare_field("ones_total", want.ones, got.ones);
      compare_field("runs_total", want.runs, got.runs);
      compare_field("words_seen", want.words, got.words);
      compare_field("pair_square_sum", want.pair_sq, got.pair_sq);
      compare_field("nibble_square_sum", want.nib_sq, got.nib_sq);
      compare_field("frequency_pass", want.freq_ok, got.freq_ok);
      compare_field("runs_pass", want.runs_ok, got.runs_ok);
      compare_field("pair_pass", want.pair_ok, got.pair_ok);
      compare_field("nibble_pass", want.nib_ok, got.nib_ok);
      compare_field("overflow_flag", want.ovf, got.ovf);
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [WORD_W-1:0]   word_in   = '0;
  logic                last_word = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ONES_W-1:0]   ones_total;
  logic [RUNS_W-1:0]   runs_total;
  logic [WORDS_W-1:0]  words_seen;
  logic [S2_OUT_W-1:0] pair_square_sum;
  logic [S4_OUT_W-1:0] nibble_square_sum;
  logic                frequency_pass, runs_pass, pair_pass, nibble_pass, overflow_flag;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ADDR_W-1:0]   paddr     = '0;
  logic [DATA_W-1:0]   pwdata    = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  sample_scoreboard sb = new();
  sample_result_t   seen;

  // Idling rates in percent of cycles, changed by the stimulus between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // A long receiver hold-off is requested by bumping hold_requests; the
  // receiver process serves it and counts the held cycles itself.
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  bit_stream_randomness_tests_unit #(.MAX_WORDS(MAX_WORDS)) dut (
    .clk, .rst,
    .in_valid, .in_stall, .word_in, .last_word,
    .out_valid, .out_stall,
    .ones_total, .runs_total, .words_seen, .pair_square_sum, .nibble_square_sum,
    .frequency_pass, .runs_pass, .pair_pass, .nibble_pass, .overflow_flag,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk = ~clk;

  // Result side. Outputs are sampled at the rising edge before the block's own
  // updates land, so a transfer is seen exactly when valid is high and stall is
  // low at that edge. The stall for the next cycle is chosen afterwards.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen.ones    = ones_total;
      seen.runs    = runs_total;
      seen.words   = words_seen;
      seen.pair_sq = pair_square_sum;
      seen.nib_sq  = nibble_square_sum;
      seen.freq_ok = frequency_pass;
      seen.runs_ok = runs_pass;
      seen.pair_ok = pair_pass;
      seen.nib_ok  = nibble_pass;
      seen.ovf     = overflow_flag;
      sb.check_result(seen);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog: a run that stops making progress ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("bit_stream_randomness_tests_unit_test: done, errors");
      $finish;
    end
  end

  // Offers one word, after a random number of idle cycles, and holds it until
  // the block takes the transfer. Valid stays high afterwards so that the next
  // word can follow back to back; whoever comes next decides whether it drops.
  task automatic send_word(logic [WORD_W-1:0] w, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    word_in   <= w;
    last_word <= last;
    do @(posedge clk); while (in_stall);
    sb.note_word(w, last);
  endtask

  // Stops offering words, waits for every outstanding result and then lets the
  // block's end-of-sample latency run out, so that it is certainly idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access until pready. The upper half of
  // the data bus carries random bits, which the 16-bit registers must drop.
  task automatic reg_write(logic [2:0] idx, logic [THR_W-1:0] value);
    logic [DATA_W-1:0] data;
    data    = {16'($urandom), value};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_check(logic [2:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.compare_field("register read", sb.register_value(idx), prdata[THR_W-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes all five thresholds, then every unused address (those writes must be
  // dropped), and reads the five back.
  task automatic set_thresholds(logic [THR_W-1:0] z, logic [THR_W-1:0] plo,
                                logic [THR_W-1:0] phi, logic [THR_W-1:0] nlo,
                                logic [THR_W-1:0] nhi);
    reg_write(REG_Z_LIMIT, z);
    reg_write(REG_PAIR_LO, plo);
    reg_write(REG_PAIR_HI, phi);
    reg_write(REG_NIB_LO, nlo);
    reg_write(REG_NIB_HI, nhi);
    for (int i = REG_NIB_HI + 1; i < REG_SLOTS; i++) reg_write(3'(i), 16'($urandom));
    for (int i = REG_Z_LIMIT; i <= REG_NIB_HI; i++) reg_check(3'(i));
  endtask

  // Random samples: mostly a handful of words, now and then a few dozen. The
  // content is mostly uniform random, with some skewed and some highly
  // regular words so that every pass flag is seen both ways.
  task automatic send_samples(int word_budget);
    int sent, len;
    logic [WORD_W-1:0] w;
    sent = 0;
    while (sent < word_budget) begin
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 9))
          0:       w = $urandom & $urandom & $urandom;
          1:       w = $urandom | $urandom | $urandom;
          2:       w = {4{8'($urandom)}};
          3: begin
            case ($urandom_range(0, 3))
              0:       w = '0;
              1:       w = '1;
              2:       w = 32'hAAAA_AAAA;
              default: w = 32'h5555_5555;
            endcase
          end
          default: w = $urandom;
        endcase
        send_word(w, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed samples on the reset thresholds: constant words, alternating
    // bits for the most runs, runs that do and do not continue across a word
    // boundary, and samples with perfectly even pair and nibble counts.
    send_idle_pct = 24;
    recv_idle_pct = 74;
    send_word(32'h0000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'hAAAA_AAAA, 1'b1);
    send_word(32'h5555_5555, 1'b0);
    send_word(32'hAAAA_AAAA, 1'b1);
    send_word(32'h0000_FFFF, 1'b0);
    send_word(32'h0000_FFFF, 1'b1);
    send_word(32'h0123_4567, 1'b0);
    send_word(32'h89AB_CDEF, 1'b1);
    send_word(32'h1B1B_1B1B, 1'b0);
    send_word(32'hE4E4_E4E4, 1'b1);
    send_word(32'h8000_0001, 1'b0);
    send_word(32'h7FFF_FFFE, 1'b1);
    send_word(32'h9669_6996, 1'b0);
    send_word(32'h6996_9669, 1'b0);
    send_word(32'hC3C3_C3C3, 1'b0);
    send_word(32'h3C3C_3C3C, 1'b1);
    wait_idle();

    // Widest acceptance bands with a zero z limit: the chi-square tests pass
    // unless the sample is badly skewed, the z tests only on a perfect balance.
    set_thresholds('0, '0, '1, '0, '1);
    send_samples(530);
    wait_idle();

    // Every threshold at its maximum: the lower chi-square bounds now reject
    // almost everything and the z tests accept almost everything.
    send_idle_pct = 74;
    recv_idle_pct = 24;
    set_thresholds('1, '1, '1, '1, '1);
    send_samples(530);
    wait_idle();

    // Random thresholds and no idling on either side. Midway the receiver holds
    // off for a long stretch while words keep coming, which fills the block and
    // stalls its input; after that the sender pauses until all results are in.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_thresholds(16'($urandom_range(200, 2000)), 16'($urandom_range(0, 300)),
                   16'($urandom_range(1000, 4000)), 16'($urandom_range(500, 2500)),
                   16'($urandom_range(4000, 10000)));
    send_samples(270);
    hold_requests++;
    send_samples(270);
    wait_idle();

    if (sb.errors == 0) begin
      $display("bit_stream_randomness_tests_unit_test: done, clean");
    end else begin
      $display("bit_stream_randomness_tests_unit_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
